// ===== rtl/core/cpf_pkg.sv =====
// shared constants, types and helper functions of the control packet framer
// no dependencies
package cpf_pkg;

  localparam int FRAME_LEN = 15;
  localparam int CRC_SPAN  = 13;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  localparam logic [7:0]  HDR0     = 8'h70;
  localparam logic [7:0]  HDR1     = 8'h63;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // -9.8 and 22.0 degrees in radians, rounded to float32
  localparam logic [31:0] PITCH_MIN_BITS = 32'hBE2F25B4;
  localparam logic [31:0] PITCH_MAX_BITS = 32'h3EC49809;

  localparam logic [7:0] MODE_IDLE  = 8'd0;
  localparam logic [7:0] MODE_CTRL  = 8'd1;
  localparam logic [7:0] MODE_SHOOT = 8'd2;

  // byte positions in the frame
  localparam logic [IDX_W-1:0] IDX_FIRST  = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(CRC_SPAN);
  localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(FRAME_LEN - 1);

  // bytes covered by the crc, byte 0 first
  typedef logic [CRC_SPAN-1:0][7:0] frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } slot_t;

  function automatic logic f32_is_nan(input logic [31:0] b);
    return b[30:0] > 31'h7F800000;
  endfunction

  // unsigned key that sorts like float order for non-nan patterns
  function automatic logic [31:0] f32_key(input logic [31:0] b);
    return b[31] ? ~b : (b | 32'h80000000);
  endfunction

  function automatic logic [31:0] clamp_pitch(input logic [31:0] b);
    logic [31:0] r;
    r = b;
    if (!f32_is_nan(b)) begin
      if (f32_key(b) < f32_key(PITCH_MIN_BITS)) begin
        r = PITCH_MIN_BITS;
      end else if (f32_key(b) > f32_key(PITCH_MAX_BITS)) begin
        r = PITCH_MAX_BITS;
      end
    end
    return r;
  endfunction

  // one byte through the reflected crc16 register
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {8'h00, d};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/cpf_cmd_if.sv =====
// command channel: valid/ready handshake with the gimbal command fields
// no dependencies
interface cpf_cmd_if;
  logic        valid;
  logic        ready;
  logic        control;
  logic        shoot;
  logic [31:0] yaw_bits;
  logic [31:0] pitch_bits;
  logic [7:0]  tgt_num;
  logic [7:0]  tgt_flag;

  modport source (output valid, control, shoot, yaw_bits, pitch_bits, tgt_num,
                  tgt_flag, input ready);
  modport sink (input valid, control, shoot, yaw_bits, pitch_bits, tgt_num,
                tgt_flag, output ready);
endinterface

// ===== rtl/core/cpf_byte_if.sv =====
// frame byte channel: valid/ready handshake with one byte and a last marker
// no dependencies
interface cpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

// ===== rtl/core/cpf_pack.sv =====
// input register: clamps pitch and lays out the thirteen crc-covered bytes
// depends on cpf_pkg and cpf_cmd_if
module cpf_pack (
  input  logic            clk,
  input  logic            rst,
  cpf_cmd_if.sink         cmd,
  input  logic            take,
  output cpf_pkg::slot_t  slot
);

  logic                slot_valid;
  cpf_pkg::frame_t     slot_frame;
  cpf_pkg::frame_t     frame_next;
  logic [31:0]         pitch;
  logic [7:0]          mode;
  logic                cmd_fire;

  assign cmd.ready = !slot_valid || take;
  assign cmd_fire  = cmd.valid && cmd.ready;

  always_comb begin
    pitch = cpf_pkg::clamp_pitch(cmd.pitch_bits);
    if (!cmd.control) begin
      mode = cpf_pkg::MODE_IDLE;
    end else if (cmd.shoot) begin
      mode = cpf_pkg::MODE_SHOOT;
    end else begin
      mode = cpf_pkg::MODE_CTRL;
    end
    frame_next[0]  = cpf_pkg::HDR0;
    frame_next[1]  = cpf_pkg::HDR1;
    frame_next[2]  = mode;
    frame_next[3]  = cmd.yaw_bits[7:0];
    frame_next[4]  = cmd.yaw_bits[15:8];
    frame_next[5]  = cmd.yaw_bits[23:16];
    frame_next[6]  = cmd.yaw_bits[31:24];
    frame_next[7]  = pitch[7:0];
    frame_next[8]  = pitch[15:8];
    frame_next[9]  = pitch[23:16];
    frame_next[10] = pitch[31:24];
    frame_next[11] = cmd.tgt_num;
    frame_next[12] = cmd.tgt_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (cmd_fire) begin
      slot_valid <= 1'b1;
    end else if (take) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      slot_frame <= frame_next;
    end
  end

  assign slot = '{valid: slot_valid, frame: slot_frame};

`ifndef SYNTHESIS
  // a held frame is not overwritten before the serializer takes it
  a_slot_hold: assert property (@(posedge clk) disable iff (rst)
    slot_valid && !take |=> slot_valid && $stable(slot_frame))
    else $error("cpf_pack: pending frame lost");
  // taking needs something to take
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    take |-> slot_valid)
    else $error("cpf_pack: take from empty slot");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> slot_valid)
    else $error("cpf_pack: accepted item not held");
`endif

endmodule

// ===== rtl/core/cpf_serializer.sv =====
// byte serializer: one frame byte a cycle while frm is ready; data bytes go into crc
// depends on cpf_pkg and cpf_byte_if
module cpf_serializer (
  input  logic                       clk,
  input  logic                       rst,
  input  cpf_pkg::slot_t             slot,
  output logic                       take,
  cpf_byte_if.source                 frm
);

  logic                        busy;
  logic [cpf_pkg::IDX_W-1:0]   idx;
  logic [15:0]                 crc;
  cpf_pkg::frame_t             frame;
  logic [7:0]                  cur_byte;
  logic                        out_fire;
  logic                        at_last;

  always_comb begin
    case (idx)
      cpf_pkg::IDX_CRC_LO: cur_byte = crc[7:0];
      cpf_pkg::IDX_CRC_HI: cur_byte = crc[15:8];
      default:             cur_byte = frame[idx];
    endcase
  end

  assign at_last        = (idx == cpf_pkg::IDX_CRC_HI);
  assign frm.valid      = busy;
  assign frm.frame_byte = cur_byte;
  assign frm.last_byte  = at_last;
  assign out_fire       = busy && frm.ready;
  // next frame loads the cycle after the last byte leaves, no bubble
  assign take           = slot.valid && (!busy || (out_fire && at_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= cpf_pkg::IDX_FIRST;
    end else if (take) begin
      busy <= 1'b1;
      idx  <= cpf_pkg::IDX_FIRST;
    end else if (out_fire) begin
      busy <= !at_last;
      idx  <= at_last ? cpf_pkg::IDX_FIRST : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame <= slot.frame;
      crc   <= cpf_pkg::CRC_INIT;
    end else if (out_fire && idx < cpf_pkg::IDX_CRC_LO) begin
      crc <= cpf_pkg::crc16_byte(crc, cur_byte);
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= cpf_pkg::IDX_CRC_HI)
    else $error("cpf_serializer: byte index out of range");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    out_fire && !at_last |=> busy && idx == $past(idx) + 1'b1)
    else $error("cpf_serializer: byte index did not advance");
  a_chain: assert property (@(posedge clk) disable iff (rst)
    out_fire && at_last && slot.valid |=> busy && idx == cpf_pkg::IDX_FIRST)
    else $error("cpf_serializer: queued frame not started");
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_fire && at_last && !slot.valid |=> !busy)
    else $error("cpf_serializer: stayed busy after last byte");
`endif

endmodule

// ===== rtl/core/control_packet_framer_crc16.sv =====
// gimbal command framer: one command in, fifteen frame bytes out with modbus crc16
// flow: an accepted command is registered in the input register and then in the
// serializer registers, which present its first byte; if the serializer is busy, the
// command waits in the input register until the last byte of the frame ahead leaves,
// and its first byte follows in the next cycle; one byte per cycle while frm is ready
// reset: rst, synchronous, clears the input register and serializer valid flags
module control_packet_framer_crc16 (
  input  logic        clk,
  input  logic        rst,
  cpf_cmd_if.sink     cmd,
  cpf_byte_if.source  frm
);

  // pending frame handed from the input register to the serializer
  cpf_pkg::slot_t slot;
  // serializer takes the pending frame when idle or on the last byte of the current one
  logic           take;

  // stage one: registers the command after pitch clamp and byte layout, so a new
  // command is taken while the previous frame is still being sent
  cpf_pack u_pack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .take (take),
    .slot (slot)
  );

  // stage two: walks the thirteen data bytes, builds the crc one byte per cycle as they
  // go out while frm is ready, then appends crc low and high bytes with the last marker
  cpf_serializer u_ser (
    .clk  (clk),
    .rst  (rst),
    .slot (slot),
    .take (take),
    .frm  (frm)
  );

endmodule
